@@ design/tdf_pkg.sv @@
package tdf_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int LEN_W  = 16;
    localparam int SEQ_W  = 32;
    localparam int ID_W   = 2;
    localparam int HELD_W = 17;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_FINITE_MODE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_BYTES = 1'b1;

    localparam logic [CFG_DATA_W-1:0] BUFFER_BYTES_RESET = 16'd16384;

    localparam logic ACT_ARRIVAL = 1'b0;
    localparam logic ACT_TX_DONE = 1'b1;

    localparam logic [2:0] EV_NONE       = 3'd0;
    localparam logic [2:0] EV_SENT_NOW   = 3'd1;
    localparam logic [2:0] EV_QUEUED     = 3'd2;
    localparam logic [2:0] EV_DROP_BYTES = 3'd3;
    localparam logic [2:0] EV_SENT_QUEUE = 3'd4;
    localparam logic [2:0] EV_DROP_FULL  = 3'd5;

    typedef struct packed {
        logic             action;
        logic [LEN_W-1:0] pkt_length;
        logic [SEQ_W-1:0] seq_number;
        logic [ID_W-1:0]  source_id;
        logic [ID_W-1:0]  dest_id;
    } in_item_t;

    typedef struct packed {
        logic [2:0]       event_kind;
        logic [LEN_W-1:0] out_length;
        logic [SEQ_W-1:0] out_seq;
        logic [ID_W-1:0]  out_source;
        logic [ID_W-1:0]  out_dest;
        logic [LEN_W-1:0] free_bytes;
        logic             free_valid;
    } out_item_t;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [SEQ_W-1:0] seq;
        logic [ID_W-1:0]  src;
        logic [ID_W-1:0]  dst;
    } desc_t;

    typedef struct packed {
        logic             en;
        logic [PTR_W-1:0] addr;
        desc_t            data;
    } store_wr_t;

endpackage

@@ design/tail_drop_byte_fifo_forwarder_top.sv @@
// Tail-drop output port buffer for packet descriptors.
// Input channel (in_valid / in_stall / in_item): an item is either a packet
// arrival or a link transmit-done event. Output channel (out_valid /
// out_stall / out_item): exactly one result per input item, in order.
// Configuration: cfg_we with cfg_index / cfg_data writes finite_mode (index 0)
// or buffer_bytes (index 1); write only while no item is in flight.
// Throughput: one item per cycle while in_stall is low. Each item's decision, counter and byte
// update and FIFO write or pop happen in the cycle it is accepted; the head
// descriptor is kept prefetched in a register by the descriptor memory.
// Output: each result is registered in the output register, or in the second slot while that is held.
// Stall: a second output slot catches one result while out_stall is high;
// in_stall rises only once both slots are full, and drops the cycle after
// the receiver takes an item.
// Reset: link idle, queue empty, held bytes zero, finite_mode 1,
// buffer_bytes 16384. The descriptor memory is not cleared; entries are
// only read after they are written.
module tail_drop_byte_fifo_forwarder_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  tdf_pkg::in_item_t               in_item,
    output logic                            out_valid,
    input  logic                            out_stall,
    output tdf_pkg::out_item_t              out_item,
    input  logic                            cfg_we,
    input  logic [tdf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tdf_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic                            finite_mode_reg;
    logic [tdf_pkg::LEN_W-1:0]       buffer_bytes_reg;
    logic                            link_busy_reg,   link_busy_next;
    logic [tdf_pkg::PTR_W-1:0]       head_ptr_reg,    head_ptr_next;
    logic [tdf_pkg::PTR_W-1:0]       tail_ptr_reg,    tail_ptr_next;
    logic [tdf_pkg::CNT_W-1:0]       entry_count_reg, entry_count_next;
    logic [tdf_pkg::HELD_W-1:0]      held_bytes_reg,  held_bytes_next;

    logic                            out_valid_reg, out_valid_next;
    logic                            skid_valid_reg, skid_valid_next;
    tdf_pkg::out_item_t              out_item_reg, skid_item_reg;

    tdf_pkg::desc_t                  pkt;
    tdf_pkg::desc_t                  head_data;
    tdf_pkg::store_wr_t              wr;
    tdf_pkg::out_item_t              res;

    logic                            accept;
    logic                            out_take;
    logic [tdf_pkg::HELD_W:0]        sum_bytes;
    logic                            over_bytes;
    logic                            queue_full;
    logic                            queue_empty;

    tdf_store u_store (
        .clk       (clk),
        .wr        (wr),
        .rd_addr   (head_ptr_next),
        .head_data (head_data)
    );

    assign accept   = in_valid && !skid_valid_reg;
    assign out_take = out_valid_reg && !out_stall;
    assign in_stall = skid_valid_reg;

    assign pkt.len = in_item.pkt_length;
    assign pkt.seq = in_item.seq_number;
    assign pkt.src = in_item.source_id;
    assign pkt.dst = in_item.dest_id;

    assign sum_bytes   = {2'b00, pkt.len} + {1'b0, held_bytes_reg};
    assign over_bytes  = sum_bytes > {2'b00, buffer_bytes_reg};
    assign queue_full  = entry_count_reg == tdf_pkg::CNT_W'(tdf_pkg::QUEUE_DEPTH);
    assign queue_empty = entry_count_reg == '0;

    always_comb
    begin
        link_busy_next   = link_busy_reg;
        head_ptr_next    = head_ptr_reg;
        tail_ptr_next    = tail_ptr_reg;
        entry_count_next = entry_count_reg;
        held_bytes_next  = held_bytes_reg;
        wr.en            = 1'b0;
        wr.addr          = tail_ptr_reg;
        wr.data          = pkt;
        res.event_kind   = tdf_pkg::EV_NONE;
        res.out_length   = pkt.len;
        res.out_seq      = pkt.seq;
        res.out_source   = pkt.src;
        res.out_dest     = pkt.dst;
        res.free_valid   = 1'b0;

        if (in_item.action == tdf_pkg::ACT_ARRIVAL)
        begin
            priority if (!link_busy_reg)
            begin
                if (accept)
                begin
                    link_busy_next = 1'b1;
                end
                res.event_kind = tdf_pkg::EV_SENT_NOW;
            end
            else if (finite_mode_reg && over_bytes)
            begin
                res.event_kind = tdf_pkg::EV_DROP_BYTES;
            end
            else if (queue_full)
            begin
                res.event_kind = tdf_pkg::EV_DROP_FULL;
            end
            else
            begin
                res.event_kind = tdf_pkg::EV_QUEUED;
                res.free_valid = finite_mode_reg;
                if (accept)
                begin
                    wr.en            = 1'b1;
                    tail_ptr_next    = (tail_ptr_reg == tdf_pkg::PTR_W'(tdf_pkg::QUEUE_DEPTH - 1))
                                       ? '0 : tail_ptr_reg + 1'b1;
                    entry_count_next = entry_count_reg + 1'b1;
                    if (finite_mode_reg)
                    begin
                        held_bytes_next = sum_bytes[tdf_pkg::HELD_W-1:0];
                    end
                end
            end
        end
        else if (queue_empty)
        begin
            res.event_kind = tdf_pkg::EV_NONE;
            res.out_length = '0;
            res.out_seq    = '0;
            res.out_source = '0;
            res.out_dest   = '0;
            if (accept)
            begin
                link_busy_next = 1'b0;
            end
        end
        else
        begin
            res.event_kind = tdf_pkg::EV_SENT_QUEUE;
            res.out_length = head_data.len;
            res.out_seq    = head_data.seq;
            res.out_source = head_data.src;
            res.out_dest   = head_data.dst;
            res.free_valid = finite_mode_reg;
            if (accept)
            begin
                link_busy_next   = 1'b1;
                head_ptr_next    = (head_ptr_reg == tdf_pkg::PTR_W'(tdf_pkg::QUEUE_DEPTH - 1))
                                   ? '0 : head_ptr_reg + 1'b1;
                entry_count_next = entry_count_reg - 1'b1;
                if (finite_mode_reg)
                begin
                    // saturate: mode may have been switched with bytes unaccounted
                    held_bytes_next = (held_bytes_reg >= {1'b0, head_data.len})
                                      ? held_bytes_reg - {1'b0, head_data.len} : '0;
                end
            end
        end

        res.free_bytes = (held_bytes_next >= {1'b0, buffer_bytes_reg})
                         ? '0
                         : tdf_pkg::LEN_W'({1'b0, buffer_bytes_reg} - held_bytes_next);
    end

    // two-slot output buffer
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                skid_valid_next = 1'b0;
            end
        end
        else if (accept)
        begin
            out_valid_next = 1'b1;
            if (out_valid_reg && !out_take)
            begin
                skid_valid_next = 1'b1;
            end
        end
        else if (out_take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_item_reg <= skid_item_reg;
            end
        end
        else if (accept)
        begin
            if (!out_valid_reg || out_take)
            begin
                out_item_reg <= res;
            end
            else
            begin
                skid_item_reg <= res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            finite_mode_reg  <= 1'b1;
            buffer_bytes_reg <= tdf_pkg::BUFFER_BYTES_RESET;
            link_busy_reg    <= 1'b0;
            head_ptr_reg     <= '0;
            tail_ptr_reg     <= '0;
            entry_count_reg  <= '0;
            held_bytes_reg   <= '0;
            out_valid_reg    <= 1'b0;
            skid_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    tdf_pkg::CFG_FINITE_MODE:  finite_mode_reg  <= cfg_data[0];
                    tdf_pkg::CFG_BUFFER_BYTES: buffer_bytes_reg <= cfg_data;
                endcase
            end
            link_busy_reg   <= link_busy_next;
            head_ptr_reg    <= head_ptr_next;
            tail_ptr_reg    <= tail_ptr_next;
            entry_count_reg <= entry_count_next;
            held_bytes_reg  <= held_bytes_next;
            out_valid_reg   <= out_valid_next;
            skid_valid_reg  <= skid_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

@@ design/tdf_store.sv @@
// Descriptor memory with a registered head read. Reading at the next head
// address each cycle keeps head_data equal to the entry at the head pointer;
// a write to that same address is forwarded.
module tdf_store (
    input  logic                       clk,
    input  tdf_pkg::store_wr_t         wr,
    input  logic [tdf_pkg::PTR_W-1:0]  rd_addr,
    output tdf_pkg::desc_t             head_data
);

    tdf_pkg::desc_t mem [tdf_pkg::QUEUE_DEPTH];
    tdf_pkg::desc_t head_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (wr.en && (wr.addr == rd_addr))
        begin
            head_data_reg <= wr.data;
        end
        else
        begin
            head_data_reg <= mem[rd_addr];
        end
    end

    assign head_data = head_data_reg;

endmodule

@@ sim/tb_top.sv @@
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tdf_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 210;
    localparam int HOLD_OFF    = 300;
    localparam int SETTLE      = 3;

    typedef struct {
        bit                is_cfg;
        bit                mode;
        logic [LEN_W-1:0]  limit;
        in_item_t          item;
        bit                typed;
        out_item_t         want;
    } row_t;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    in_item_t              in_item   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_item_t             out_item;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // hand-typed expectation riding along with the item on offer
    bit                    typed_valid = 1'b0;
    out_item_t             typed_want  = '0;

    // forwarder state as the testbench sees it
    bit                    link_active;
    desc_t                 queued_pkts[$];
    int                    held_total;
    bit                    finite_on;
    logic [LEN_W-1:0]      byte_limit;

    out_item_t             pending_events[$];
    out_item_t             predicted;
    int                    events_checked;
    int                    mismatches;
    int                    hold_cycles;
    bit                    quiet;
    row_t                  dir_rows[$];

    bit                    phase_mode[PHASES]    = '{1, 0, 1, 1, 1, 0, 1, 1};
    logic [LEN_W-1:0]      phase_limit[PHASES]   =
        '{16384, 1000, 65535, 0, 0, 65535, 3000, 16384};
    int                    phase_arr_pct[PHASES] = '{60, 85, 85, 40, 55, 50, 70, 50};

    tail_drop_byte_fifo_forwarder_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic in_item_t mk_item(logic act, logic [LEN_W-1:0] len,
                                         logic [SEQ_W-1:0] seq, logic [ID_W-1:0] src,
                                         logic [ID_W-1:0] dst);
        return '{act, len, seq, src, dst};
    endfunction

    function automatic out_item_t mk_event(logic [2:0] kind, logic [LEN_W-1:0] len,
                                           logic [SEQ_W-1:0] seq, logic [ID_W-1:0] src,
                                           logic [ID_W-1:0] dst, logic [LEN_W-1:0] free,
                                           logic valid);
        return '{kind, len, seq, src, dst, free, valid};
    endfunction

    function automatic row_t step_row(in_item_t it, bit typed, out_item_t want);
        return '{1'b0, 1'b0, '0, it, typed, want};
    endfunction

    function automatic row_t cfg_row(bit mode, logic [LEN_W-1:0] limit);
        return '{1'b1, mode, limit, '0, 1'b0, '0};
    endfunction

    // One arrival or transmit-done: update the queue state, return the event.
    function automatic out_item_t forward_step(in_item_t it);
        out_item_t r;
        desc_t     pkt;
        desc_t     shown;
        int        room;
        r     = '0;
        pkt   = '{it.pkt_length, it.seq_number, it.source_id, it.dest_id};
        shown = pkt;
        if (it.action == ACT_ARRIVAL)
        begin
            if (!link_active)
            begin
                link_active  = 1'b1;
                r.event_kind = EV_SENT_NOW;
            end
            else if (finite_on && int'(pkt.len) + held_total > int'(byte_limit))
            begin
                r.event_kind = EV_DROP_BYTES;
            end
            else if (queued_pkts.size() >= QUEUE_DEPTH)
            begin
                r.event_kind = EV_DROP_FULL;
            end
            else
            begin
                queued_pkts.push_back(pkt);
                r.event_kind = EV_QUEUED;
                if (finite_on)
                begin
                    held_total  += int'(pkt.len);
                    r.free_valid = 1'b1;
                end
            end
        end
        else if (queued_pkts.size() == 0)
        begin
            link_active  = 1'b0;
            shown        = '0;
            r.event_kind = EV_NONE;
        end
        else
        begin
            shown        = queued_pkts.pop_front();
            link_active  = 1'b1;
            r.event_kind = EV_SENT_QUEUE;
            if (finite_on)
            begin
                // mode may have flipped while packets sat in the queue
                held_total   = (held_total >= int'(shown.len))
                               ? held_total - int'(shown.len) : 0;
                r.free_valid = 1'b1;
            end
        end
        r.out_length = shown.len;
        r.out_seq    = shown.seq;
        r.out_source = shown.src;
        r.out_dest   = shown.dst;
        room         = int'(byte_limit) - held_total;
        r.free_bytes = (room < 0) ? '0 : LEN_W'(room);
        return r;
    endfunction

    task automatic report(string what, longint unsigned got, longint unsigned want);
        mismatches++;
        $display("event %0d: %s got 0x%0h, want 0x%0h", events_checked, what, got, want);
    endtask

    task automatic check_event(out_item_t got);
        out_item_t want;
        events_checked++;
        if (pending_events.size() == 0)
        begin
            report("unrequested item, kind", got.event_kind, 0);
            return;
        end
        want = pending_events.pop_front();
        if (got.event_kind !== want.event_kind)
            report("event_kind", got.event_kind, want.event_kind);
        if (got.out_length !== want.out_length)
            report("out_length", got.out_length, want.out_length);
        if (got.out_seq !== want.out_seq)
            report("out_seq", got.out_seq, want.out_seq);
        if (got.out_source !== want.out_source)
            report("out_source", got.out_source, want.out_source);
        if (got.out_dest !== want.out_dest)
            report("out_dest", got.out_dest, want.out_dest);
        if (got.free_bytes !== want.free_bytes)
            report("free_bytes", got.free_bytes, want.free_bytes);
        if (got.free_valid !== want.free_valid)
            report("free_valid", got.free_valid, want.free_valid);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                check_event(out_item);
            if (cfg_we)
            begin
                if (cfg_index == CFG_FINITE_MODE)
                    finite_on = cfg_data[0];
                else if (cfg_index == CFG_BUFFER_BYTES)
                    byte_limit = cfg_data;
            end
            if (in_valid && !in_stall)
            begin
                predicted = forward_step(in_item);
                pending_events.push_back(typed_valid ? typed_want : predicted);
            end
        end
    end

    task automatic offer_item(in_item_t it, bit typed, out_item_t want);
        in_item     <= it;
        in_valid    <= 1'b1;
        typed_valid <= typed;
        typed_want  <= want;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    task automatic wait_all_events();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic program_port(bit mode, logic [LEN_W-1:0] limit);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_FINITE_MODE;
        cfg_data  <= {{(CFG_DATA_W-1){1'b0}}, mode};
        @(posedge clk);
        cfg_index <= CFG_BUFFER_BYTES;
        cfg_data  <= limit;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // receiver side: short stall bursts, plus one long hold-off on request
    initial
    begin
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_cycles > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
            end
            else if (!quiet && $urandom_range(0, 4) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
                repeat (quiet ? 1 : $urandom_range(1, 15)) @(posedge clk);
            end
        end
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        in_item_t         it;
        logic [LEN_W-1:0] limit;
        int               pick;

        link_active    = 1'b0;
        held_total     = 0;
        finite_on      = 1'b1;
        byte_limit     = BUFFER_BYTES_RESET;
        events_checked = 0;
        mismatches     = 0;
        hold_cycles    = 0;
        quiet          = 1'b0;

        // reset defaults: finite mode, 16384 byte limit
        dir_rows.push_back(step_row(mk_item(ACT_TX_DONE, 16'd0, 32'd0, 2'd0, 2'd0), 1'b1,
            mk_event(EV_NONE, 16'd0, 32'd0, 2'd0, 2'd0, 16'd16384, 1'b0)));
        dir_rows.push_back(step_row(mk_item(ACT_ARRIVAL, 16'hFFFF, 32'hFFFF_FFFF, 2'd3, 2'd3),
            1'b1, mk_event(EV_SENT_NOW, 16'hFFFF, 32'hFFFF_FFFF, 2'd3, 2'd3, 16'd16384, 1'b0)));
        dir_rows.push_back(step_row(mk_item(ACT_ARRIVAL, 16'd16385, 32'd1, 2'd1, 2'd2), 1'b1,
            mk_event(EV_DROP_BYTES, 16'd16385, 32'd1, 2'd1, 2'd2, 16'd16384, 1'b0)));
        // exactly at the limit fits
        dir_rows.push_back(step_row(mk_item(ACT_ARRIVAL, 16'd16384, 32'd0, 2'd0, 2'd0), 1'b1,
            mk_event(EV_QUEUED, 16'd16384, 32'd0, 2'd0, 2'd0, 16'd0, 1'b1)));
        dir_rows.push_back(step_row(mk_item(ACT_ARRIVAL, 16'd0, 32'h8000_0005, 2'd2, 2'd1),
            1'b1, mk_event(EV_QUEUED, 16'd0, 32'h8000_0005, 2'd2, 2'd1, 16'd0, 1'b1)));
        dir_rows.push_back(step_row(mk_item(ACT_ARRIVAL, 16'd1, 32'h1234_5678, 2'd3, 2'd0),
            1'b1, mk_event(EV_DROP_BYTES, 16'd1, 32'h1234_5678, 2'd3, 2'd0, 16'd0, 1'b0)));
        // unlimited mode, limit now below held bytes
        dir_rows.push_back(cfg_row(1'b0, 16'd100));
        dir_rows.push_back(step_row(mk_item(ACT_ARRIVAL, 16'd40000, 32'd7, 2'd1, 2'd0), 1'b1,
            mk_event(EV_QUEUED, 16'd40000, 32'd7, 2'd1, 2'd0, 16'd0, 1'b0)));
        dir_rows.push_back(step_row(mk_item(ACT_TX_DONE, 16'hA5A5, 32'hFFFF_0000, 2'd3, 2'd3),
            1'b1, mk_event(EV_SENT_QUEUE, 16'd16384, 32'd0, 2'd0, 2'd0, 16'd0, 1'b0)));
        // back to finite: dequeue of an unaccounted packet clamps held bytes at zero
        dir_rows.push_back(cfg_row(1'b1, 16'd65535));
        dir_rows.push_back(step_row(mk_item(ACT_TX_DONE, 16'd0, 32'd0, 2'd0, 2'd0), 1'b1,
            mk_event(EV_SENT_QUEUE, 16'd0, 32'h8000_0005, 2'd2, 2'd1, 16'd49151, 1'b1)));
        dir_rows.push_back(step_row(mk_item(ACT_TX_DONE, 16'd0, 32'd0, 2'd0, 2'd0), 1'b1,
            mk_event(EV_SENT_QUEUE, 16'd40000, 32'd7, 2'd1, 2'd0, 16'd65535, 1'b1)));
        dir_rows.push_back(step_row(mk_item(ACT_TX_DONE, 16'd0, 32'd0, 2'd0, 2'd0), 1'b1,
            mk_event(EV_NONE, 16'd0, 32'd0, 2'd0, 2'd0, 16'd65535, 1'b0)));
        dir_rows.push_back(step_row(mk_item(ACT_ARRIVAL, 16'd1234, 32'h5A5A_A5A5, 2'd2, 2'd3),
            1'b0, '0));
        dir_rows.push_back(step_row(mk_item(ACT_ARRIVAL, 16'hFFFF, 32'h0F0F_F0F0, 2'd1, 2'd2),
            1'b1, mk_event(EV_QUEUED, 16'hFFFF, 32'h0F0F_F0F0, 2'd1, 2'd2, 16'd0, 1'b1)));
        dir_rows.push_back(cfg_row(1'b1, 16'd0));
        dir_rows.push_back(step_row(mk_item(ACT_ARRIVAL, 16'd0, 32'h0000_FFFF, 2'd0, 2'd3),
            1'b1, mk_event(EV_DROP_BYTES, 16'd0, 32'h0000_FFFF, 2'd0, 2'd3, 16'd0, 1'b0)));
        dir_rows.push_back(step_row(mk_item(ACT_TX_DONE, 16'd0, 32'd0, 2'd0, 2'd0), 1'b0, '0));
        dir_rows.push_back(step_row(mk_item(ACT_ARRIVAL, 16'd0, 32'hDEAD_BEEF, 2'd1, 2'd1),
            1'b0, '0));
        dir_rows.push_back(step_row(mk_item(ACT_TX_DONE, 16'd0, 32'd0, 2'd0, 2'd0), 1'b0, '0));
        dir_rows.push_back(step_row(mk_item(ACT_TX_DONE, 16'd0, 32'd0, 2'd0, 2'd0), 1'b0, '0));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].is_cfg)
            begin
                wait_all_events();
                program_port(dir_rows[i].mode, dir_rows[i].limit);
            end
            else
            begin
                offer_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
            end
        end

        for (int p = 0; p < PHASES; p++)
        begin
            wait_all_events();
            quiet = (p == PHASES - 1);
            limit = (p == 4) ? LEN_W'($urandom_range(0, 65535)) : phase_limit[p];
            program_port(phase_mode[p], limit);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // long receiver hold-off while items keep coming
                if (p == 2 && n == 20)
                    hold_cycles = HOLD_OFF;
                if (p == 3 && n == 100)
                    wait_all_events();
                it.action     = ($urandom_range(0, 99) < phase_arr_pct[p]) ? ACT_ARRIVAL
                                                                          : ACT_TX_DONE;
                pick          = $urandom_range(0, 9);
                it.pkt_length = (pick == 0) ? '0 :
                                (pick == 1) ? '1 :
                                (pick == 2) ? LEN_W'($urandom) :
                                              LEN_W'($urandom_range(1, 1500));
                it.seq_number = $urandom;
                it.source_id  = ID_W'($urandom_range(0, 3));
                it.dest_id    = ID_W'($urandom_range(0, 3));
                offer_item(it, 1'b0, '0);
            end
        end

        wait_all_events();
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
